// ===== sv/acx_pkg.sv =====
// shared types, status codes and base decode for the ambiguous codon expander
package acx_pkg;

   localparam int CODON_COUNT = 64;
   localparam int CODON_BITS  = 6;
   localparam int COUNT_BITS  = 7;
   localparam int BYTE_COUNT  = CODON_COUNT / 8;

   localparam logic [CODON_COUNT-1:0] STOP_MASK_RESET = 64'h0000_0000_0000_4C00;

   localparam logic [1:0] STATUS_CODON     = 2'd0;
   localparam logic [1:0] STATUS_STOP_ONLY = 2'd1;
   localparam logic [1:0] STATUS_FORBIDDEN = 2'd2;

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;

   typedef struct packed {
      logic [7:0] char_code;
      logic       seq_start;
   } req_data_type;

   typedef struct packed {
      logic [CODON_BITS-1:0] codon_index;
      logic [1:0]            site_status;
      logic                  ambiguous;
      logic [COUNT_BITS-1:0] alternative_count;
      logic                  last_of_site;
   } rsp_data_type;

   // controller to datapath
   typedef struct packed {
      logic take;
      logic calc;
      logic sum;
      logic head;
      logic next;
   } acx_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic bad_char;
      logic third_base;
      logic rsp_busy;
      logic count_zero;
      logic count_one;
      logic last_low;
   } acx_status_type;

   // bit 0 T, bit 1 C, bit 2 A, bit 3 G; zero marks a forbidden character
   function automatic logic [3:0] base_set_of(input logic [7:0] code);
      logic [7:0] c;
      logic [3:0] s;
      c = code;
      if (code inside {[8'h61:8'h7A]}) begin
         c = code - 8'd32;
      end
      case (c)
         "T", "U":           s = 4'h1;
         "C":                s = 4'h2;
         "A":                s = 4'h4;
         "G":                s = 4'h8;
         "M":                s = 4'h6;
         "R":                s = 4'hC;
         "W":                s = 4'h5;
         "S":                s = 4'hA;
         "Y":                s = 4'h3;
         "K":                s = 4'h9;
         "B":                s = 4'hB;
         "D":                s = 4'hD;
         "H":                s = 4'h7;
         "V":                s = 4'hE;
         "-", "N", "X", "?": s = 4'hF;
         default:            s = 4'h0;
      endcase
      return s;
   endfunction

endpackage

// ===== sv/acx_ctrl.sv =====
// control state machine that sequences capture, counting and emission of a site
module acx_ctrl
   import acx_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  acx_status_type status,
   output acx_cmd_type    cmd
);

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_CALC = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_HEAD = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            // an error result needs the output register free
            req_stall = status.bad_char && status.rsp_busy;
            if (req_valid && !req_stall) begin
               cmd.take = 1'b1;
               if (status.third_base) begin
                  state_in = ST_CALC;
               end
            end
         end
         ST_CALC: begin
            cmd.calc = 1'b1;
            state_in = ST_SUM;
         end
         ST_SUM: begin
            cmd.sum  = 1'b1;
            state_in = ST_HEAD;
         end
         ST_HEAD: begin
            if (!status.rsp_busy) begin
               cmd.head = 1'b1;
               if (status.count_zero || status.count_one) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_EMIT;
               end
            end
         end
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.next = 1'b1;
               if (status.last_low) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== sv/acx_dpath.sv =====
// datapath: triplet phase, base sets, sense mask, counts and output register
module acx_dpath
   import acx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CODON_COUNT-1:0] csr_wr_data,
   input  acx_cmd_type            cmd,
   output acx_status_type         status
);

   logic [1:0]             phase_ff, phase_in;
   logic [3:0]             first_ff, first_in;
   logic [3:0]             second_ff, second_in;
   logic [CODON_COUNT-1:0] stop_mask_ff, stop_mask_in;
   logic [CODON_COUNT-1:0] mask_ff, mask_in;
   logic [3:0]             cnt8_ff [BYTE_COUNT];
   logic [3:0]             cnt8_in [BYTE_COUNT];
   logic [CODON_BITS-1:0]  high_ff, high_in;
   logic [COUNT_BITS-1:0]  count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_data_type           rsp_data_ff, rsp_data_in;

   logic [3:0]             base_set;
   logic [1:0]             eff_phase;
   logic [CODON_COUNT-1:0] sense;
   logic [CODON_BITS-1:0]  high_idx;
   logic [CODON_BITS-1:0]  low_idx;
   logic [CODON_COUNT-1:0] mask_low_cleared;
   logic                   rsp_load;

   function automatic logic [3:0] popcount8(input logic [7:0] v);
      logic [3:0] n;
      n = '0;
      for (int i = 0; i < 8; i++) begin
         n = n + 4'(v[i]);
      end
      return n;
   endfunction

   // highest set bit: pick the top nonzero byte, then the top bit in it
   function automatic logic [CODON_BITS-1:0] highest_index(input logic [CODON_COUNT-1:0] m);
      logic [2:0] b;
      logic [2:0] t;
      logic [7:0] v;
      b = '0;
      t = '0;
      for (int i = 0; i < BYTE_COUNT; i++) begin
         if (|m[8*i +: 8]) begin
            b = 3'(i);
         end
      end
      v = m[{b, 3'b000} +: 8];
      for (int i = 0; i < 8; i++) begin
         if (v[i]) begin
            t = 3'(i);
         end
      end
      return {b, t};
   endfunction

   function automatic logic [CODON_BITS-1:0] lowest_index(input logic [CODON_COUNT-1:0] m);
      logic [2:0] b;
      logic [2:0] t;
      logic [7:0] v;
      b = '0;
      t = '0;
      for (int i = BYTE_COUNT - 1; i >= 0; i--) begin
         if (|m[8*i +: 8]) begin
            b = 3'(i);
         end
      end
      v = m[{b, 3'b000} +: 8];
      for (int i = 7; i >= 0; i--) begin
         if (v[i]) begin
            t = 3'(i);
         end
      end
      return {b, t};
   endfunction

   assign base_set  = base_set_of(req_data.char_code);
   assign eff_phase = req_data.seq_start ? PHASE_FIRST : phase_ff;

   // every codon the three sets allow, minus the stop codons
   always_comb begin
      sense = '0;
      for (int i = 0; i < 4; i++) begin
         for (int j = 0; j < 4; j++) begin
            for (int k = 0; k < 4; k++) begin
               sense[16*i + 4*j + k] = first_ff[i] & second_ff[j] & base_set[k]
                                       & ~stop_mask_ff[16*i + 4*j + k];
            end
         end
      end
   end

   assign high_idx = highest_index(mask_ff);
   assign low_idx  = lowest_index(mask_ff);

   always_comb begin
      mask_low_cleared          = mask_ff;
      mask_low_cleared[low_idx] = 1'b0;
   end

   always_comb begin
      phase_in     = phase_ff;
      first_in     = first_ff;
      second_in    = second_ff;
      stop_mask_in = csr_wr_en ? csr_wr_data : stop_mask_ff;
      mask_in      = mask_ff;
      cnt8_in      = cnt8_ff;
      high_in      = high_ff;
      count_in     = count_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_load     = 1'b0;

      if (cmd.take) begin
         if (base_set == 4'h0) begin
            phase_in                = PHASE_FIRST;
            first_in                = '0;
            second_in               = '0;
            rsp_load                = 1'b1;
            rsp_data_in             = '0;
            rsp_data_in.site_status = STATUS_FORBIDDEN;
            rsp_data_in.last_of_site = 1'b1;
         end else if (eff_phase == PHASE_SECOND) begin
            second_in = base_set;
            phase_in  = PHASE_THIRD;
         end else if (eff_phase == PHASE_THIRD) begin
            phase_in = PHASE_FIRST;
            mask_in  = sense;
         end else begin
            first_in = base_set;
            phase_in = PHASE_SECOND;
         end
      end

      if (cmd.calc) begin
         for (int b = 0; b < BYTE_COUNT; b++) begin
            cnt8_in[b] = popcount8(mask_ff[8*b +: 8]);
         end
         high_in           = high_idx;
         // the head codon leaves the ascending run
         mask_in[high_idx] = 1'b0;
      end

      if (cmd.sum) begin
         count_in = '0;
         for (int b = 0; b < BYTE_COUNT; b++) begin
            count_in = count_in + COUNT_BITS'(cnt8_ff[b]);
         end
      end

      if (cmd.head) begin
         rsp_load    = 1'b1;
         rsp_data_in = '0;
         if (count_ff == '0) begin
            rsp_data_in.site_status  = STATUS_STOP_ONLY;
            rsp_data_in.last_of_site = 1'b1;
         end else begin
            rsp_data_in.codon_index       = high_ff;
            rsp_data_in.site_status       = STATUS_CODON;
            rsp_data_in.ambiguous         = count_ff > COUNT_BITS'(1);
            rsp_data_in.alternative_count = count_ff;
            rsp_data_in.last_of_site      = count_ff == COUNT_BITS'(1);
         end
      end

      if (cmd.next) begin
         rsp_load                      = 1'b1;
         rsp_data_in.codon_index       = low_idx;
         rsp_data_in.site_status       = STATUS_CODON;
         rsp_data_in.ambiguous         = 1'b1;
         rsp_data_in.alternative_count = count_ff;
         rsp_data_in.last_of_site      = mask_low_cleared == '0;
         mask_in                       = mask_low_cleared;
      end

      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else begin
         rsp_valid_in = rsp_valid_ff && rsp_stall;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PHASE_FIRST;
         first_ff     <= '0;
         second_ff    <= '0;
         stop_mask_ff <= STOP_MASK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         first_ff     <= first_in;
         second_ff    <= second_in;
         stop_mask_ff <= stop_mask_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mask_ff     <= mask_in;
      cnt8_ff     <= cnt8_in;
      high_ff     <= high_in;
      count_ff    <= count_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign status.bad_char   = base_set == 4'h0;
   assign status.third_base = (base_set != 4'h0) && (eff_phase == PHASE_THIRD);
   assign status.rsp_busy   = rsp_valid_ff && rsp_stall;
   assign status.count_zero = count_ff == '0;
   assign status.count_one  = count_ff == COUNT_BITS'(1);
   assign status.last_low   = mask_low_cleared == '0;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/ambiguous_codon_expander_top.sv =====
// Ambiguous codon expander: takes one nucleotide character per req_ transfer and
// returns the sense codons of each completed triplet on the rsp_ channel, the
// highest codon first and then the rest in ascending order. First and second
// bases of a triplet are taken without a stall and give no result; a forbidden
// character gives one error result and restarts the triplet. After the third
// base the block holds req_stall high while it counts the site in the CALC and
// SUM states; the HEAD state then loads the first result, the others follow one
// per cycle while rsp_stall is low, and the next character is taken only after
// the last result of the site (or its single stop status) is loaded into the
// output register. The count and the ordered run come from a 64-bit sense mask
// register, a per-byte popcount stage and highest/lowest-bit searches on it.
// csr_wr_data replaces the stop codon mask; write it only while the block is idle.
module ambiguous_codon_expander_top
   import acx_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data,
   input  logic                   csr_wr_en,
   input  logic [CODON_COUNT-1:0] csr_wr_data
);

   acx_cmd_type    cmd;
   acx_status_type status;

   acx_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   acx_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status)
   );

endmodule

// ===== sv/acx_checker.sv =====
// port-level checks for the ambiguous codon expander and their bind
module acx_checker
   import acx_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   // a held result keeps its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result changed");

   // stop-only and error results close their site and carry no codons
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.site_status != STATUS_CODON)
      |-> rsp_data.last_of_site && (rsp_data.alternative_count == '0)
          && !rsp_data.ambiguous)
      else $error("non-codon result malformed");

   // codon results carry a count that agrees with the ambiguity flag
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.site_status == STATUS_CODON)
      |-> (rsp_data.alternative_count != '0)
          && (rsp_data.ambiguous == (rsp_data.alternative_count > 7'd1)))
      else $error("codon count and ambiguity disagree");

   // after a transfer that is not last, the next result stays in the same site
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_data.last_of_site ##1 rsp_valid
      |-> (rsp_data.site_status == STATUS_CODON)
          && $stable(rsp_data.alternative_count))
      else $error("site run broken");

endmodule

bind ambiguous_codon_expander_top acx_checker u_acx_checker (.*);

// ===== dv/ambiguous_codon_expander_top_test.sv =====
// self-checking stream test of the ambiguous codon expander with a built-in codon site predictor
`timescale 1ns / 100ps

module ambiguous_codon_expander_top_test
   import acx_pkg::*;
();

   localparam int CYCLE_LIMIT     = 400000;
   localparam int PHASE_ITEMS     = 64;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int SETTLE_CYCLES   = 16;

   typedef struct {
      req_data_type item;
      bit           typed;
      rsp_data_type want;
   } script_row_type;

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   req_data_type           req_data;
   logic                   rsp_valid;
   logic                   rsp_stall;
   rsp_data_type           rsp_data;
   logic                   csr_wr_en;
   logic [CODON_COUNT-1:0] csr_wr_data;

   // predictor copy of the block state
   logic [CODON_COUNT-1:0] stop_mask_q;
   logic [1:0]             phase_q;
   logic [3:0]             first_q;
   logic [3:0]             second_q;

   rsp_data_type   site_codons[$];
   rsp_data_type   awaited_codons[$];
   script_row_type script[$];
   int             mismatches;
   bit             calm;
   bit             hold_off_pending;

   ambiguous_codon_expander_top i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic logic [3:0] nucleotide_mask(input logic [7:0] ch);
      logic [7:0] up;
      up = (ch >= "a" && ch <= "z") ? ch - 8'd32 : ch;
      case (up)
         "T", "U":           return 4'b0001;
         "C":                return 4'b0010;
         "A":                return 4'b0100;
         "G":                return 4'b1000;
         "M":                return 4'b0110;
         "R":                return 4'b1100;
         "W":                return 4'b0101;
         "S":                return 4'b1010;
         "Y":                return 4'b0011;
         "K":                return 4'b1001;
         "B":                return 4'b1011;
         "D":                return 4'b1101;
         "H":                return 4'b0111;
         "V":                return 4'b1110;
         "-", "N", "X", "?": return 4'b1111;
         default:            return 4'b0000;
      endcase
   endfunction

   function automatic rsp_data_type make_rsp(input int codon, input logic [1:0] status,
                                             input bit amb, input int count, input bit closing);
      rsp_data_type r;
      r.codon_index       = codon[CODON_BITS-1:0];
      r.site_status       = status;
      r.ambiguous         = amb;
      r.alternative_count = count[COUNT_BITS-1:0];
      r.last_of_site      = closing;
      return r;
   endfunction

   // fills site_codons with what one accepted character produces
   task automatic expand_site(input req_data_type d);
      logic [3:0]             third;
      logic [CODON_COUNT-1:0] sense;
      int                     count;
      int                     top;
      site_codons.delete();
      third = nucleotide_mask(d.char_code);
      if (d.seq_start) begin
         phase_q = PHASE_FIRST;
      end
      if (third == 4'b0000) begin
         phase_q  = PHASE_FIRST;
         first_q  = 4'b0000;
         second_q = 4'b0000;
         site_codons.push_back(make_rsp(0, STATUS_FORBIDDEN, 1'b0, 0, 1'b1));
      end else if (phase_q == PHASE_SECOND) begin
         second_q = third;
         phase_q  = PHASE_THIRD;
      end else if (phase_q != PHASE_THIRD) begin
         first_q = third;
         phase_q = PHASE_SECOND;
      end else begin
         phase_q = PHASE_FIRST;
         sense   = '0;
         count   = 0;
         top     = 0;
         for (int i = 0; i < CODON_COUNT; i++) begin
            if (first_q[i / 16] && second_q[(i / 4) % 4] && third[i % 4] && !stop_mask_q[i]) begin
               sense[i] = 1'b1;
               count++;
               top = i;
            end
         end
         if (count == 0) begin
            site_codons.push_back(make_rsp(0, STATUS_STOP_ONLY, 1'b0, 0, 1'b1));
         end else begin
            // highest codon leads, the rest follow in ascending order
            site_codons.push_back(make_rsp(top, STATUS_CODON, count > 1, count, count == 1));
            for (int i = 0; i < CODON_COUNT; i++) begin
               if (i != top && sense[i]) begin
                  site_codons.push_back(make_rsp(i, STATUS_CODON, 1'b1, count,
                                                 site_codons.size() + 1 == count));
               end
            end
         end
      end
   endtask

   // called at a falling edge, returns at the falling edge after the transfer
   task automatic send_char(input req_data_type d, input bit typed, input rsp_data_type want);
      while (!calm && $urandom_range(0, 99) < 12) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_data  = d;
      do @(posedge clock); while (req_stall);
      expand_site(d);
      if (typed) begin
         site_codons.delete();
         site_codons.push_back(want);
      end
      foreach (site_codons[n]) awaited_codons.push_back(site_codons[n]);
      @(negedge clock);
   endtask

   task automatic add_row(input logic [7:0] ch, input bit restart, input bit typed,
                          input rsp_data_type want);
      script_row_type row;
      row.item.char_code = ch;
      row.item.seq_start = restart;
      row.typed          = typed;
      row.want           = want;
      script.push_back(row);
   endtask

   function automatic logic [7:0] pick_char();
      string plain = "TCAGUtcagu";
      string codes = "MRWSYKBDHVmrwsykbdhv";
      string any   = "-NX?nx";
      int    roll;
      roll = $urandom_range(0, 99);
      if (roll < 60) return plain[$urandom_range(0, plain.len() - 1)];
      if (roll < 82) return codes[$urandom_range(0, codes.len() - 1)];
      if (roll < 90) return any[$urandom_range(0, any.len() - 1)];
      return 8'($urandom_range(0, 255));
   endfunction

   task automatic wait_idle();
      req_valid = 1'b0;
      while (awaited_codons.size() != 0) @(posedge clock);
      // a first or second base may still be in flight
      repeat (8) @(negedge clock);
   endtask

   task automatic set_stop_mask(input logic [CODON_COUNT-1:0] mask);
      csr_wr_en   = 1'b1;
      csr_wr_data = mask;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      stop_mask_q = mask;
   endtask

   task automatic flag_field(input string name, input int want, input int got);
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
   endtask

   always @(posedge clock) begin
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_codons.size() == 0) begin
            mismatches++;
            $display("%0t: result with nothing expected, actual codon %0d status %0d",
                     $time, rsp_data.codon_index, rsp_data.site_status);
         end else begin
            want = awaited_codons.pop_front();
            if (rsp_data.codon_index !== want.codon_index)
               flag_field("codon_index", want.codon_index, rsp_data.codon_index);
            if (rsp_data.site_status !== want.site_status)
               flag_field("site_status", want.site_status, rsp_data.site_status);
            if (rsp_data.ambiguous !== want.ambiguous)
               flag_field("ambiguous", want.ambiguous, rsp_data.ambiguous);
            if (rsp_data.alternative_count !== want.alternative_count)
               flag_field("alternative_count", want.alternative_count,
                          rsp_data.alternative_count);
            if (rsp_data.last_of_site !== want.last_of_site)
               flag_field("last_of_site", want.last_of_site, rsp_data.last_of_site);
         end
      end
   end

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_pending) begin
            hold_off_pending = 1'b0;
            rsp_stall = 1'b1;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end
         rsp_stall = !calm && ($urandom_range(0, 99) < 12);
      end
   end

   initial begin
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("Verification failed");
      $finish;
   end

   initial begin
      logic [CODON_COUNT-1:0] mask_plan [6];
      req_data_type           d;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_data         = '0;
      csr_wr_en        = 1'b0;
      csr_wr_data      = '0;
      mismatches       = 0;
      calm             = 1'b0;
      hold_off_pending = 1'b0;
      stop_mask_q      = STOP_MASK_RESET;
      phase_q          = PHASE_FIRST;
      first_q          = 4'b0000;
      second_q         = 4'b0000;

      add_row("A", 1'b1, 1'b0, '0);
      add_row("T", 1'b0, 1'b0, '0);
      add_row("G", 1'b0, 1'b1, make_rsp(35, STATUS_CODON, 1'b0, 1, 1'b1));   // ATG
      add_row("C", 1'b0, 1'b0, '0);
      add_row(8'h00, 1'b0, 1'b1, make_rsp(0, STATUS_FORBIDDEN, 1'b0, 0, 1'b1));
      add_row("t", 1'b0, 1'b0, '0);
      add_row("a", 1'b0, 1'b0, '0);
      add_row("a", 1'b0, 1'b1, make_rsp(0, STATUS_STOP_ONLY, 1'b0, 0, 1'b1));
      add_row("U", 1'b1, 1'b0, '0);
      add_row("r", 1'b0, 1'b0, '0);
      add_row("a", 1'b0, 1'b1, make_rsp(0, STATUS_STOP_ONLY, 1'b0, 0, 1'b1));
      add_row("N", 1'b0, 1'b0, '0);
      add_row("n", 1'b0, 1'b0, '0);
      add_row("-", 1'b0, 1'b0, '0);                                           // every sense codon
      add_row("g", 1'b0, 1'b0, '0);
      add_row("G", 1'b0, 1'b0, '0);
      add_row("g", 1'b0, 1'b1, make_rsp(63, STATUS_CODON, 1'b0, 1, 1'b1));
      add_row("C", 1'b0, 1'b0, '0);
      add_row("A", 1'b0, 1'b0, '0);
      add_row(8'hFF, 1'b0, 1'b1, make_rsp(0, STATUS_FORBIDDEN, 1'b0, 0, 1'b1));
      add_row("C", 1'b0, 1'b0, '0);
      add_row("G", 1'b1, 1'b0, '0);                                           // restart mid triplet
      add_row("x", 1'b0, 1'b0, '0);
      add_row("?", 1'b0, 1'b0, '0);
      add_row("t", 1'b0, 1'b0, '0);
      add_row("u", 1'b0, 1'b0, '0);
      add_row("T", 1'b0, 1'b1, make_rsp(0, STATUS_CODON, 1'b0, 1, 1'b1));

      mask_plan[0] = '0;
      mask_plan[1] = '1;
      mask_plan[2] = {$urandom, $urandom};
      mask_plan[3] = {$urandom, $urandom} & {$urandom, $urandom};
      mask_plan[4] = {$urandom, $urandom} | {$urandom, $urandom};
      mask_plan[5] = STOP_MASK_RESET;

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (script[n]) send_char(script[n].item, script[n].typed, script[n].want);

      for (int p = 0; p < 6; p++) begin
         wait_idle();
         set_stop_mask(mask_plan[p]);
         calm = (p == 2);
         for (int k = 0; k < PHASE_ITEMS; k++) begin
            if (p == 0 && k == 8) begin
               hold_off_pending = 1'b1;
            end
            d.char_code = pick_char();
            d.seq_start = ($urandom_range(0, 99) < 5);
            send_char(d, 1'b0, '0);
         end
      end
      calm = 1'b0;

      req_valid = 1'b0;
      while (awaited_codons.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
